[src/flight_phase_detector_unit_defines.svh]
// assertion macros for the flight phase detector
`ifndef FLIGHT_PHASE_DETECTOR_UNIT_DEFINES_SVH
`define FLIGHT_PHASE_DETECTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[src/fpd_pkg.sv]
`timescale 1ns / 1ps
package fpd_pkg;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LIFTOFF_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPLOY_ALT        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_ACC_TOL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_GYRO_TOL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TD_ACC_TOL        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TD_GYRO_TOL       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BURN_TICKS    = 3'd6;

   localparam logic [14:0] LIFTOFF_THRESHOLD_RST = 15'd3000;
   localparam logic [22:0] DEPLOY_ALT_RST        = 23'd2000;
   localparam logic [15:0] CALIB_ACC_TOL_RST     = 16'd50;
   localparam logic [15:0] CALIB_GYRO_TOL_RST    = 16'd100;
   localparam logic [15:0] TD_ACC_TOL_RST        = 16'd100;
   localparam logic [15:0] TD_GYRO_TOL_RST       = 16'd200;
   localparam logic [31:0] MIN_BURN_TICKS_RST    = 32'd1000;

   localparam logic [15:0] CALIB_COUNT     = 16'd100;
   localparam logic [15:0] LIFTOFF_COUNT   = 16'd5;
   localparam logic [15:0] BURNOUT_COUNT   = 16'd3;
   localparam logic [15:0] APOGEE_COUNT    = 16'd3;
   localparam logic [15:0] MAIN_COUNT      = 16'd5;
   localparam logic [15:0] TOUCHDOWN_COUNT = 16'd100;

   typedef enum logic [2:0] {
      PH_CALIB     = 3'd0,
      PH_READY     = 3'd1,
      PH_THRUST    = 3'd2,
      PH_COAST     = 3'd3,
      PH_DROGUE    = 3'd4,
      PH_MAIN      = 3'd5,
      PH_TOUCHDOWN = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EVT_NONE       = 3'd0,
      EVT_ARMED      = 3'd1,
      EVT_LAUNCH     = 3'd2,
      EVT_BURNOUT    = 3'd3,
      EVT_PEAK       = 3'd4,
      EVT_MAIN_CHUTE = 3'd5,
      EVT_LANDED     = 3'd6
   } event_type;

   // three axes, index 0 is x
   typedef logic [2:0][15:0] axis3_type;
   typedef logic [2:0][30:0] square3_type;

   typedef struct packed {
      logic signed [15:0] acc_x;
      logic signed [15:0] acc_y;
      logic signed [15:0] acc_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [23:0] est_height;
      logic signed [23:0] est_velocity;
      logic signed [23:0] est_accel;
      logic [31:0]        tick_now;
   } req_type;

   typedef struct packed {
      phase_type  phase;
      logic       phase_changed;
      event_type  event_code;
   } rsp_type;

   typedef struct packed {
      logic [29:0] liftoff_sq;
      logic [22:0] deploy_alt;
      logic [15:0] calib_acc_tol;
      logic [15:0] calib_gyro_tol;
      logic [15:0] td_acc_tol;
      logic [15:0] td_gyro_tol;
      logic [31:0] min_burn_ticks;
   } cfg_type;

endpackage

[src/fpd_motion.sv]
`timescale 1ns / 1ps
module fpd_motion (
   input  fpd_pkg::axis3_type prev_acc,
   input  fpd_pkg::axis3_type prev_gyro,
   input  fpd_pkg::axis3_type acc,
   input  fpd_pkg::axis3_type gyro,
   input  logic [15:0]        acc_tol,
   input  logic [15:0]        gyro_tol,
   output logic               still
);
   import fpd_pkg::*;

   function automatic logic near(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] tol);
      logic signed [16:0] diff;
      logic [16:0]        mag;
      diff = signed'({a[15], a}) - signed'({b[15], b});
      mag  = diff[16] ? 17'(-diff) : 17'(diff);
      return mag < {1'b0, tol};
   endfunction

   always_comb begin
      still = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (!near(prev_acc[i], acc[i], acc_tol)) still = 1'b0;
         if (!near(prev_gyro[i], gyro[i], gyro_tol)) still = 1'b0;
      end
   end

endmodule

[src/fpd_csr.sv]
`timescale 1ns / 1ps
module fpd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [fpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output fpd_pkg::cfg_type                cfg
);
   import fpd_pkg::*;

   logic [14:0] liftoff_thr_ff;
   logic [29:0] liftoff_sq_ff;
   logic [29:0] liftoff_sq_in;
   logic [22:0] main_alt_ff;
   logic [15:0] calib_acc_tol_ff;
   logic [15:0] calib_gyro_tol_ff;
   logic [15:0] td_acc_tol_ff;
   logic [15:0] td_gyro_tol_ff;
   logic [31:0] min_burn_ff;

   // threshold is squared once here and held, keeping the multiplier off the item path
   assign liftoff_sq_in = 30'(liftoff_thr_ff * liftoff_thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         liftoff_thr_ff    <= LIFTOFF_THRESHOLD_RST;
         liftoff_sq_ff     <= 30'(LIFTOFF_THRESHOLD_RST * LIFTOFF_THRESHOLD_RST);
         main_alt_ff       <= DEPLOY_ALT_RST;
         calib_acc_tol_ff  <= CALIB_ACC_TOL_RST;
         calib_gyro_tol_ff <= CALIB_GYRO_TOL_RST;
         td_acc_tol_ff     <= TD_ACC_TOL_RST;
         td_gyro_tol_ff    <= TD_GYRO_TOL_RST;
         min_burn_ff       <= MIN_BURN_TICKS_RST;
      end else begin
         liftoff_sq_ff <= liftoff_sq_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_LIFTOFF_THRESHOLD: liftoff_thr_ff    <= csr_wdata[14:0];
               CSR_DEPLOY_ALT:        main_alt_ff       <= csr_wdata[22:0];
               CSR_CALIB_ACC_TOL:     calib_acc_tol_ff  <= csr_wdata[15:0];
               CSR_CALIB_GYRO_TOL:    calib_gyro_tol_ff <= csr_wdata[15:0];
               CSR_TD_ACC_TOL:        td_acc_tol_ff     <= csr_wdata[15:0];
               CSR_TD_GYRO_TOL:       td_gyro_tol_ff    <= csr_wdata[15:0];
               CSR_MIN_BURN_TICKS:    min_burn_ff       <= csr_wdata[31:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.liftoff_sq     = liftoff_sq_ff;
   assign cfg.deploy_alt     = main_alt_ff;
   assign cfg.calib_acc_tol  = calib_acc_tol_ff;
   assign cfg.calib_gyro_tol = calib_gyro_tol_ff;
   assign cfg.td_acc_tol     = td_acc_tol_ff;
   assign cfg.td_gyro_tol    = td_gyro_tol_ff;
   assign cfg.min_burn_ticks = min_burn_ff;

endmodule

[src/fpd_phase.sv]
`timescale 1ns / 1ps
module fpd_phase (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  fpd_pkg::req_type     item,
   input  fpd_pkg::square3_type acc_sq,
   input  fpd_pkg::cfg_type     cfg,
   output fpd_pkg::rsp_type     result
);
   import fpd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] phase_cnt_ff, phase_cnt_in;
   logic [15:0] liftoff_cnt_ff, liftoff_cnt_in;
   axis3_type   prev_acc_ff, prev_acc_in;
   axis3_type   prev_gyro_ff, prev_gyro_in;
   logic [31:0] burnout_tick_ff, burnout_tick_in;

   axis3_type   acc, gyro;
   logic [15:0] acc_tol, gyro_tol;
   logic        still;
   logic [31:0] mag_sq;
   logic [31:0] burn_dt;
   logic signed [24:0] height_ext, main_alt_ext;
   logic        below_main;

   function automatic logic [15:0] bump(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   assign acc  = {item.acc_z, item.acc_y, item.acc_x};
   assign gyro = {item.gyro_z, item.gyro_y, item.gyro_x};

   assign acc_tol  = (phase_ff == PH_CALIB) ? cfg.calib_acc_tol : cfg.td_acc_tol;
   assign gyro_tol = (phase_ff == PH_CALIB) ? cfg.calib_gyro_tol : cfg.td_gyro_tol;

   fpd_motion u_motion (
      .prev_acc  (prev_acc_ff),
      .prev_gyro (prev_gyro_ff),
      .acc       (acc),
      .gyro      (gyro),
      .acc_tol   (acc_tol),
      .gyro_tol  (gyro_tol),
      .still     (still)
   );

   // three squares of at most 2^30 each fit in 32 bits
   assign mag_sq = 32'(acc_sq[0]) + 32'(acc_sq[1]) + 32'(acc_sq[2]);

   assign burn_dt      = item.tick_now - burnout_tick_ff;
   assign height_ext   = {item.est_height[23], item.est_height};
   assign main_alt_ext = {2'b00, cfg.deploy_alt};
   assign below_main   = height_ext < main_alt_ext;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      phase_cnt_in    = phase_cnt_ff;
      liftoff_cnt_in  = liftoff_cnt_ff;
      prev_acc_in     = prev_acc_ff;
      prev_gyro_in    = prev_gyro_ff;
      burnout_tick_in = burnout_tick_ff;
      case (phase_ff)
         PH_CALIB: begin
            phase_cnt_in = still ? bump(phase_cnt_ff) : 16'd0;
            prev_acc_in  = acc;
            prev_gyro_in = gyro;
            if (phase_cnt_in > CALIB_COUNT) phase_in = PH_READY;
         end
         PH_MAIN: begin
            phase_cnt_in = still ? bump(phase_cnt_ff) : 16'd0;
            prev_acc_in  = acc;
            prev_gyro_in = gyro;
            if (phase_cnt_in > TOUCHDOWN_COUNT) phase_in = PH_TOUCHDOWN;
         end
         PH_READY: begin
            liftoff_cnt_in = (mag_sq > 32'(cfg.liftoff_sq)) ? bump(liftoff_cnt_ff) : 16'd0;
            if (liftoff_cnt_in > LIFTOFF_COUNT) phase_in = PH_THRUST;
         end
         PH_THRUST: begin
            phase_cnt_in = item.est_accel[23] ? bump(phase_cnt_ff) : 16'd0;
            if (phase_cnt_in > BURNOUT_COUNT) phase_in = PH_COAST;
         end
         PH_COAST: begin
            // positive velocity leaves the count alone
            if (item.est_velocity[23]) phase_cnt_in = bump(phase_cnt_ff);
            if (phase_cnt_in > APOGEE_COUNT) begin
               phase_in = (burn_dt < cfg.min_burn_ticks) ? PH_TOUCHDOWN : PH_DROGUE;
            end
         end
         PH_DROGUE: begin
            phase_cnt_in = below_main ? bump(phase_cnt_ff) : 16'd0;
            if (phase_cnt_in > MAIN_COUNT) phase_in = PH_MAIN;
         end
         default: ;
      endcase
      if (phase_in != phase_ff) begin
         phase_cnt_in   = 16'd0;
         liftoff_cnt_in = 16'd0;
         if (phase_ff == PH_THRUST) burnout_tick_in = item.tick_now;
      end
   end

   // outputs: the event follows from the phase entered
   always_comb begin
      result.phase         = phase_in;
      result.phase_changed = (phase_in != phase_ff);
      result.event_code    = EVT_NONE;
      if (phase_in != phase_ff) begin
         case (phase_in)
            PH_READY:     result.event_code = EVT_ARMED;
            PH_THRUST:    result.event_code = EVT_LAUNCH;
            PH_COAST:     result.event_code = EVT_BURNOUT;
            PH_DROGUE:    result.event_code = EVT_PEAK;
            PH_MAIN:      result.event_code = EVT_MAIN_CHUTE;
            PH_TOUCHDOWN: result.event_code = EVT_LANDED;
            default:      result.event_code = EVT_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CALIB;
         phase_cnt_ff    <= 16'd0;
         liftoff_cnt_ff  <= 16'd0;
         prev_acc_ff     <= '0;
         prev_gyro_ff    <= '0;
         burnout_tick_ff <= 32'd0;
      end else if (item_valid) begin
         phase_ff        <= phase_in;
         phase_cnt_ff    <= phase_cnt_in;
         liftoff_cnt_ff  <= liftoff_cnt_in;
         prev_acc_ff     <= prev_acc_in;
         prev_gyro_ff    <= prev_gyro_in;
         burnout_tick_ff <= burnout_tick_in;
      end
   end

endmodule

[src/flight_phase_detector_unit.sv]
`timescale 1ns / 1ps
// flight phase detector: one control tick in, one phase report out
// req channel: valid/ready, one word per tick carrying the imu sample,
//   height, velocity and acceleration estimates and the tick count
// rsp channel: valid/ready, one word per tick with the phase after that
//   tick, a phase-changed flag and the event code raised on that tick
// csr port: write enable, register index and 32 bit data, applied at the
//   edge; write only while no tick is in flight
// path: a word accepted at an edge is loaded into the input register,
//   and its result is registered into the output register, raising
//   rsp_valid, once the output side is free
// throughput: one tick per cycle while rsp_ready is high; accel squares
//   are formed as a word enters the input register, then feed phase update
// stall: while rsp_ready is low the output register holds its word and
//   the input register still takes one more tick; req_ready drops only
//   when both registers are full
// reset: phase returns to calibrating, counters, previous samples and
//   burnout tick clear, registers take their default values
module flight_phase_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fpd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fpd_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_en,
   input  logic [fpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fpd_pkg::*;

   cfg_type     cfg;
   logic        s1_valid_ff;
   req_type     s1_data_ff;
   square3_type s1_sq_ff, s1_sq_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     result;
   logic        advance;
   logic        req_fire;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_sq_in[0] = 31'(req_data.acc_x * req_data.acc_x);
      s1_sq_in[1] = 31'(req_data.acc_y * req_data.acc_y);
      s1_sq_in[2] = 31'(req_data.acc_z * req_data.acc_z);
   end

   fpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   fpd_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (s1_data_ff),
      .acc_sq     (s1_sq_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
         s1_sq_ff   <= s1_sq_in;
      end
      if (advance) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "flight_phase_detector_unit_defines.svh"

   `FPD_ASSERT_IMPLY(a_change_has_event, clock, reset,
      rsp_valid_ff, rsp_data_ff.phase_changed == (rsp_data_ff.event_code != EVT_NONE),
      "phase change and event code disagree")
   `FPD_ASSERT_IMPLY(a_never_back_to_calib, clock, reset,
      rsp_valid_ff && rsp_data_ff.phase_changed, rsp_data_ff.phase != PH_CALIB,
      "phase changed into calibrating")
   `FPD_ASSERT_NEXT(a_touchdown_terminal, clock, reset,
      rsp_valid_ff && rsp_data_ff.phase == PH_TOUCHDOWN, rsp_data_ff.phase == PH_TOUCHDOWN,
      "left touchdown")
   `FPD_ASSERT_IMPLY(a_backpressure_only_when_full, clock, reset,
      !req_ready, s1_valid_ff && rsp_valid_ff && !rsp_ready,
      "input stalled while a register was free")

endmodule

[dv/flight_phase_detector_unit_tb.sv]
`timescale 1ns / 1ps
module flight_phase_detector_unit_tb;
   import fpd_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   flight_phase_detector_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // flight state as the block should hold it
   phase_type          fl_phase;
   logic [15:0]        phase_cnt;
   logic [15:0]        lift_cnt;
   logic signed [15:0] last_acc [3];
   logic signed [15:0] last_gyro [3];
   logic [31:0]        burnout_tick;

   logic [14:0] cfg_liftoff;
   logic [22:0] cfg_main_alt;
   logic [15:0] cfg_cal_acc;
   logic [15:0] cfg_cal_gyro;
   logic [15:0] cfg_td_acc;
   logic [15:0] cfg_td_gyro;
   logic [31:0] cfg_min_burn;

   rsp_type     flight_reports [$];
   logic [31:0] tick_clock = 32'd0;
   int          ticks_sent = 0;
   int          reports_seen = 0;
   int          failures = 0;
   int          reg_writes = 0;
   int          hold_left = 0;
   int          stall_cycles = 0;
   logic [7:0]  phases_seen = '0;
   logic [7:0]  events_seen = '0;

   function automatic void reset_flight_model();
      fl_phase = PH_CALIB;
      phase_cnt = '0;
      lift_cnt = '0;
      for (int i = 0; i < 3; i++) begin
         last_acc[i] = '0;
         last_gyro[i] = '0;
      end
      burnout_tick = '0;
      cfg_liftoff = LIFTOFF_THRESHOLD_RST;
      cfg_main_alt = DEPLOY_ALT_RST;
      cfg_cal_acc = CALIB_ACC_TOL_RST;
      cfg_cal_gyro = CALIB_GYRO_TOL_RST;
      cfg_td_acc = TD_ACC_TOL_RST;
      cfg_td_gyro = TD_GYRO_TOL_RST;
      cfg_min_burn = MIN_BURN_TICKS_RST;
   endfunction

   function automatic logic [15:0] count_up(logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   function automatic logic axis_near(logic signed [15:0] a, logic signed [15:0] b,
                                      logic [15:0] tol);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) d = -d;
      return d < int'(tol);
   endfunction

   function automatic logic imu_still(req_type w, logic [15:0] atol, logic [15:0] gtol);
      return axis_near(last_acc[0], w.acc_x, atol) && axis_near(last_acc[1], w.acc_y, atol)
         && axis_near(last_acc[2], w.acc_z, atol) && axis_near(last_gyro[0], w.gyro_x, gtol)
         && axis_near(last_gyro[1], w.gyro_y, gtol) && axis_near(last_gyro[2], w.gyro_z, gtol);
   endfunction

   function automatic event_type enter_phase(phase_type nxt, event_type ev, logic [31:0] tick);
      if (fl_phase == PH_THRUST) burnout_tick = tick;
      fl_phase = nxt;
      phase_cnt = '0;
      lift_cnt = '0;
      return ev;
   endfunction

   // one control tick through the phase machine
   function automatic rsp_type advance_flight(req_type w);
      rsp_type   r;
      phase_type old;
      event_type ev;
      logic      quiet;
      longint    mag;
      longint    thr;
      logic [31:0] dt;
      old = fl_phase;
      ev = EVT_NONE;
      case (fl_phase)
         PH_CALIB, PH_MAIN: begin
            quiet = (fl_phase == PH_CALIB) ? imu_still(w, cfg_cal_acc, cfg_cal_gyro)
                                           : imu_still(w, cfg_td_acc, cfg_td_gyro);
            phase_cnt = quiet ? count_up(phase_cnt) : '0;
            last_acc[0] = w.acc_x;
            last_acc[1] = w.acc_y;
            last_acc[2] = w.acc_z;
            last_gyro[0] = w.gyro_x;
            last_gyro[1] = w.gyro_y;
            last_gyro[2] = w.gyro_z;
            if (fl_phase == PH_CALIB) begin
               if (phase_cnt > CALIB_COUNT) ev = enter_phase(PH_READY, EVT_ARMED, w.tick_now);
            end else if (phase_cnt > TOUCHDOWN_COUNT) begin
               ev = enter_phase(PH_TOUCHDOWN, EVT_LANDED, w.tick_now);
            end
         end
         PH_READY: begin
            mag = longint'(w.acc_x) * longint'(w.acc_x) + longint'(w.acc_y) * longint'(w.acc_y)
                + longint'(w.acc_z) * longint'(w.acc_z);
            thr = longint'(cfg_liftoff) * longint'(cfg_liftoff);
            lift_cnt = (mag > thr) ? count_up(lift_cnt) : '0;
            if (lift_cnt > LIFTOFF_COUNT) ev = enter_phase(PH_THRUST, EVT_LAUNCH, w.tick_now);
         end
         PH_THRUST: begin
            phase_cnt = w.est_accel[23] ? count_up(phase_cnt) : '0;
            if (phase_cnt > BURNOUT_COUNT) ev = enter_phase(PH_COAST, EVT_BURNOUT, w.tick_now);
         end
         PH_COAST: begin
            // positive velocity leaves the count alone
            if (w.est_velocity[23]) phase_cnt = count_up(phase_cnt);
            if (phase_cnt > APOGEE_COUNT) begin
               dt = w.tick_now - burnout_tick;
               if (dt < cfg_min_burn) ev = enter_phase(PH_TOUCHDOWN, EVT_LANDED, w.tick_now);
               else ev = enter_phase(PH_DROGUE, EVT_PEAK, w.tick_now);
            end
         end
         PH_DROGUE: begin
            phase_cnt = (int'($signed(w.est_height)) < int'(cfg_main_alt)) ? count_up(phase_cnt)
                                                                         : '0;
            if (phase_cnt > MAIN_COUNT) ev = enter_phase(PH_MAIN, EVT_MAIN_CHUTE, w.tick_now);
         end
         default: ;
      endcase
      r.phase = fl_phase;
      r.phase_changed = (fl_phase != old);
      r.event_code = ev;
      return r;
   endfunction

   function automatic req_type noise_word();
      logic [$bits(req_type)-1:0] bits;
      bits = '0;
      repeat (7) bits = {bits[$bits(req_type)-33:0], $urandom()};
      return bits;
   endfunction

   function automatic req_type imu_word(int a0, int a1, int a2, int g0, int g1, int g2);
      req_type w;
      w = noise_word();
      w.acc_x = 16'(a0);
      w.acc_y = 16'(a1);
      w.acc_z = 16'(a2);
      w.gyro_x = 16'(g0);
      w.gyro_y = 16'(g1);
      w.gyro_z = 16'(g2);
      return w;
   endfunction

   // a sample within tol of the previous one, kept on the rails
   function automatic logic [15:0] near_value(logic signed [15:0] prev, logic [15:0] tol);
      int span;
      int v;
      span = int'(tol) - 1;
      v = int'(prev) + int'($urandom_range(2 * span, 0)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   // three axes each above 0.58 t clear t squared, each below 0.57 t stay under
   function automatic logic [15:0] lift_axis(bit big, int t);
      int lo;
      int mag;
      lo = t * 58 / 100 + 1;
      if (big) mag = $urandom_range(32767, lo);
      else mag = $urandom_range(t * 57 / 100, 0);
      if ($urandom_range(1, 0) == 1) mag = -mag;
      return 16'(mag);
   endfunction

   // a word that does (qual) or does not advance the count of the current phase
   function automatic req_type make_word(bit qual, bit noisy);
      req_type     w;
      logic [15:0] atol;
      logic [15:0] gtol;
      int          alt;
      int          h;
      if (noisy && $urandom_range(99, 0) < 3) return noise_word();
      w = noise_word();
      w.tick_now = tick_clock;
      tick_clock = tick_clock + 32'd1;
      case (fl_phase)
         PH_CALIB, PH_MAIN: begin
            atol = (fl_phase == PH_CALIB) ? cfg_cal_acc : cfg_td_acc;
            gtol = (fl_phase == PH_CALIB) ? cfg_cal_gyro : cfg_td_gyro;
            if (qual && atol != 0 && gtol != 0) begin
               w.acc_x = near_value(last_acc[0], atol);
               w.acc_y = near_value(last_acc[1], atol);
               w.acc_z = near_value(last_acc[2], atol);
               w.gyro_x = near_value(last_gyro[0], gtol);
               w.gyro_y = near_value(last_gyro[1], gtol);
               w.gyro_z = near_value(last_gyro[2], gtol);
            end
         end
         PH_READY: begin
            w.acc_x = lift_axis(qual, int'(cfg_liftoff));
            w.acc_y = lift_axis(qual, int'(cfg_liftoff));
            w.acc_z = lift_axis(qual, int'(cfg_liftoff));
         end
         PH_THRUST: w.est_accel[23] = qual;
         PH_COAST: w.est_velocity[23] = qual;
         PH_DROGUE: begin
            alt = int'(cfg_main_alt);
            if ($urandom_range(4, 0) == 0) h = qual ? alt - 1 : alt;
            else if (qual) h = int'($urandom_range(alt + 8388607, 0)) - 8388608;
            else h = $urandom_range(8388607, alt);
            w.est_height = 24'(h);
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_tick(req_type w);
      rsp_type exp;
      if (!(ticks_sent >= 800 && ticks_sent < 1100) && $urandom_range(99, 0) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      exp = advance_flight(w);
      flight_reports.push_back(exp);
      phases_seen[exp.phase] = 1'b1;
      events_seen[exp.event_code] = 1'b1;
      ticks_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (flight_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_LIFTOFF_THRESHOLD: cfg_liftoff = val[14:0];
         CSR_DEPLOY_ALT:        cfg_main_alt = val[22:0];
         CSR_CALIB_ACC_TOL:     cfg_cal_acc = val[15:0];
         CSR_CALIB_GYRO_TOL:    cfg_cal_gyro = val[15:0];
         CSR_TD_ACC_TOL:        cfg_td_acc = val[15:0];
         CSR_TD_GYRO_TOL:       cfg_td_gyro = val[15:0];
         CSR_MIN_BURN_TICKS:    cfg_min_burn = val;
         default: ;
      endcase
   endtask

   // up to budget words in the current phase, then optionally force it to move on
   task automatic run_phase(int budget, int pct, bit push, bit noisy);
      phase_type start;
      int        n;
      start = fl_phase;
      n = 0;
      while (fl_phase == start && n < budget) begin
         send_tick(make_word($urandom_range(99, 0) < pct, noisy));
         n++;
      end
      while (push && start != PH_TOUCHDOWN && fl_phase == start)
         send_tick(make_word(1'b1, 1'b0));
   endtask

   task automatic test_reset_defaults();
      req_type w;
      send_tick(imu_word(0, 0, 0, 0, 0, 0));
      send_tick(imu_word(49, 0, 0, 0, 0, -99));
      // acc step equal to tolerance, then gyro step equal to tolerance
      send_tick(imu_word(99, 0, 0, 0, 0, -99));
      send_tick(imu_word(99, 0, 0, 0, 0, 1));
      send_tick(imu_word(-32768, -32768, -32768, 32767, 32767, 32767));
      send_tick(imu_word(32767, 32767, 32767, -32768, -32768, -32768));
      send_tick(imu_word(32767, 32767, 32767, -32768, -32768, -32768));
      w = imu_word(32767, 32767, 32767, -32768, -32768, -32768);
      w.est_height = 24'h800000;
      w.est_velocity = 24'h7FFFFF;
      w.est_accel = 24'h800000;
      w.tick_now = 32'h0;
      send_tick(w);
      w.est_height = 24'h7FFFFF;
      w.est_velocity = 24'h800000;
      w.est_accel = 24'h7FFFFF;
      w.tick_now = 32'hFFFFFFFF;
      send_tick(w);
   endtask

   task automatic test_calibration();
      configure(CSR_CALIB_ACC_TOL, 32'd0);
      configure(CSR_CALIB_GYRO_TOL, 32'd0);
      run_phase(40, 80, 1'b0, 1'b1);
      configure(CSR_CALIB_ACC_TOL, 32'd65535);
      configure(CSR_CALIB_GYRO_TOL, 32'd65535);
      // full-scale swing misses the widest tolerance by one
      send_tick(imu_word(-32768, 0, 0, 0, 0, 0));
      send_tick(imu_word(32767, 0, 0, 0, 0, 0));
      send_tick(imu_word(-32767, 0, 0, 0, 0, 0));
      run_phase(40, 50, 1'b0, 1'b1);
      configure(CSR_CALIB_ACC_TOL, $urandom_range(3000, 1));
      configure(CSR_CALIB_GYRO_TOL, $urandom_range(3000, 1));
      run_phase(250, 93, 1'b1, 1'b1);
   endtask

   task automatic test_liftoff();
      configure(CSR_LIFTOFF_THRESHOLD, 32'd0);
      run_phase(40, 30, 1'b0, 1'b1);
      configure(CSR_LIFTOFF_THRESHOLD, 32'd32767);
      run_phase(40, 40, 1'b0, 1'b1);
      configure(CSR_LIFTOFF_THRESHOLD, $urandom_range(20000, 500));
      run_phase(200, 50, 1'b1, 1'b1);
   endtask

   task automatic test_burnout();
      // burnout lands near the tick wrap
      tick_clock = 32'hFFFFFFFF - $urandom_range(300, 0);
      run_phase(150, 30, 1'b1, 1'b1);
   endtask

   task automatic test_apogee();
      int          pushes;
      logic [31:0] apogee_dt;
      configure(CSR_MIN_BURN_TICKS, 32'd0);
      run_phase(60, 1, 1'b0, 1'b0);
      configure(CSR_MIN_BURN_TICKS, 32'hFFFFFFFF);
      run_phase(60, 1, 1'b0, 1'b0);
      if (fl_phase == PH_COAST) begin
         // minimum set right at, or one past, the burn time the apogee tick will show
         pushes = int'(APOGEE_COUNT) + 1 - int'(phase_cnt);
         apogee_dt = tick_clock + 32'(pushes - 1) - burnout_tick;
         configure(CSR_MIN_BURN_TICKS,
                   ($urandom_range(3, 0) == 0) ? apogee_dt + 32'd1 : apogee_dt);
      end
      run_phase(0, 100, 1'b1, 1'b0);
   endtask

   task automatic test_main_deploy();
      configure(CSR_DEPLOY_ALT, 32'd0);
      run_phase(40, 40, 1'b0, 1'b1);
      configure(CSR_DEPLOY_ALT, 32'd8388607);
      run_phase(40, 40, 1'b0, 1'b1);
      configure(CSR_DEPLOY_ALT, $urandom_range(5000000, 1000));
      run_phase(150, 50, 1'b1, 1'b1);
   endtask

   task automatic test_touchdown();
      configure(CSR_TD_ACC_TOL, 32'd0);
      configure(CSR_TD_GYRO_TOL, 32'd0);
      run_phase(40, 90, 1'b0, 1'b1);
      configure(CSR_TD_ACC_TOL, 32'd65535);
      configure(CSR_TD_GYRO_TOL, 32'd65535);
      run_phase(40, 90, 1'b0, 1'b1);
      configure(CSR_TD_ACC_TOL, $urandom_range(3000, 1));
      configure(CSR_TD_GYRO_TOL, $urandom_range(3000, 1));
      run_phase(250, 96, 1'b1, 1'b1);
   endtask

   task automatic test_after_touchdown();
      int n;
      n = 1900 - ticks_sent;
      if (n < 150) n = 150;
      run_phase(n, 50, 1'b0, 1'b1);
   endtask

   function automatic void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   function automatic void check_report(rsp_type got);
      rsp_type exp;
      reports_seen++;
      if (flight_reports.size() == 0) begin
         log_failure($sformatf("report %0d: unexpected word phase %0d changed %0d event %0d",
                               reports_seen, got.phase, got.phase_changed, got.event_code));
         return;
      end
      exp = flight_reports.pop_front();
      if (got.phase !== exp.phase)
         log_failure($sformatf("report %0d: phase expected %0d got %0d",
                               reports_seen, exp.phase, got.phase));
      if (got.phase_changed !== exp.phase_changed)
         log_failure($sformatf("report %0d: phase_changed expected %0d got %0d",
                               reports_seen, exp.phase_changed, got.phase_changed));
      if (got.event_code !== exp.event_code)
         log_failure($sformatf("report %0d: event_code expected %0d got %0d",
                               reports_seen, exp.event_code, got.event_code));
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         check_report(rsp_data);
         // long back-pressure so the pipe fills and req_ready drops
         if (reports_seen == 250 || reports_seen == 1450) hold_left = 80;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (reports_seen >= 800 && reports_seen < 1100) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset_flight_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_calibration();
      test_liftoff();
      test_burnout();
      test_apogee();
      test_main_deploy();
      test_touchdown();
      test_after_touchdown();
      wait_idle();
      $display("%0d ticks checked over %0d register writes, %0d failures",
               reports_seen, reg_writes, failures);
      $display("phases reached %b, events raised %b (bit n = code n)",
               phases_seen[6:0], events_seen[6:0]);
      if (failures == 0 && flight_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
